>>> rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared constants for the rational arithmetic unit
// Operation codes, datapath widths and sequencer state codes.
// ----------------------------------------------------------------------------
package rau_pkg;

  // operation codes
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // magnitude width of the raw numerator and denominator
  localparam int MAG_W = 32;
  // width of the common power-of-two count in the gcd unit
  localparam int K_W   = 5;
  // width of the divider step counter
  localparam int CNT_W = 5;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL0 = 4'd1;
  localparam logic [3:0] ST_MUL1 = 4'd2;
  localparam logic [3:0] ST_MUL2 = 4'd3;
  localparam logic [3:0] ST_FORM = 4'd4;
  localparam logic [3:0] ST_EVAL = 4'd5;
  localparam logic [3:0] ST_GCD  = 4'd6;
  localparam logic [3:0] ST_DIVN = 4'd7;
  localparam logic [3:0] ST_DIVD = 4'd8;

endpackage

>>> rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction add/sub/mul/div reduced to lowest terms
// Cross products from one shared multiplier, then a binary gcd and two exact
// divisions on a shared bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_cmd and the four 16-bit operands and raise start while busy is
//   low; the transaction is taken at that clock edge and busy stays high
//   until the result has been issued.
//   The result appears on out_res_num, out_res_den and out_err for exactly
//   one cycle with out_valid high. The receiver cannot stall; it must take
//   the result in that cycle.
// Sequence:
//   The products are taken in ST_MUL0, ST_MUL1 and ST_MUL2; ST_FORM forms
//   the raw terms and ST_EVAL tests them. A zero raw denominator (out_err
//   set) or a zero raw numerator returns straight from ST_EVAL. Otherwise
//   the gcd unit runs one step per cycle, and the divider then divides the
//   numerator and then the denominator magnitude by the gcd.
//   A new transaction may start in the cycle the result is shown.
// Reset:
//   rst_n low returns the sequencer to idle and drops out_valid; any
//   transaction in progress is abandoned.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic signed [15:0] in_num_a,
  input  logic signed [15:0] in_den_a,
  input  logic signed [15:0] in_num_b,
  input  logic signed [15:0] in_den_b,
  output logic               out_valid,
  output logic signed [31:0] out_res_num,
  output logic signed [30:0] out_res_den,
  output logic               out_err
);

  logic [3:0]         state_r;
  logic [1:0]         cmd_r;
  logic signed [15:0] na_r;
  logic signed [15:0] da_r;
  logic signed [15:0] nb_r;
  logic signed [15:0] db_r;
  logic signed [31:0] p0_r;
  logic signed [31:0] p1_r;
  logic signed [31:0] p2_r;
  logic signed [32:0] rn_r;
  logic signed [31:0] rd_r;
  logic [MAG_W-1:0]   qn_r;
  logic               valid_r;
  logic signed [31:0] res_num_r;
  logic signed [30:0] res_den_r;
  logic               err_r;

  logic signed [15:0] mul_x;
  logic signed [15:0] mul_y;
  logic signed [31:0] mul_p;
  logic signed [32:0] rn_form;
  logic signed [32:0] rn_neg;
  logic signed [31:0] rd_neg;
  logic [MAG_W-1:0]   mag_n;
  logic [MAG_W-1:0]   mag_d;

  logic               gcd_start;
  logic               gcd_done;
  logic [MAG_W-1:0]   gcd_val;
  logic               div_start;
  logic [MAG_W-1:0]   div_dividend;
  logic               div_done;
  logic [MAG_W-1:0]   div_quot;
  logic [MAG_W-1:0]   quot_neg;

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      ST_MUL0: begin
        mul_x = na_r;
        mul_y = (cmd_r == CMD_MUL) ? nb_r : db_r;
      end
      ST_MUL1: begin
        mul_x = nb_r;
        mul_y = da_r;
      end
      default: begin
        mul_x = da_r;
        mul_y = db_r;
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  always_comb begin
    case (cmd_r)
      CMD_ADD: rn_form = {p0_r[31], p0_r} + {p1_r[31], p1_r};
      CMD_SUB: rn_form = {p0_r[31], p0_r} - {p1_r[31], p1_r};
      default: rn_form = {p0_r[31], p0_r};
    endcase
  end

  assign rn_neg = -rn_r;
  assign rd_neg = -rd_r;
  assign mag_n  = rn_r[32] ? rn_neg[31:0] : rn_r[31:0];
  assign mag_d  = rd_r[31] ? rd_neg : rd_r;

  assign gcd_start    = (state_r == ST_EVAL) && (rd_r != '0) && (rn_r != '0);
  assign div_start    = gcd_done || ((state_r == ST_DIVN) && div_done);
  assign div_dividend = (state_r == ST_GCD) ? mag_n : mag_d;
  assign quot_neg     = -div_quot;

  rau_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a_in  (mag_n),
    .b_in  (mag_d),
    .done  (gcd_done),
    .gcd   (gcd_val)
  );

  // divisor stays on gcd_val: the gcd unit holds it until it finishes its next run
  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (gcd_val),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            cmd_r   <= in_cmd;
            na_r    <= in_num_a;
            da_r    <= in_den_a;
            nb_r    <= in_num_b;
            db_r    <= in_den_b;
            state_r <= ST_MUL0;
          end
        end
        ST_MUL0: begin
          p0_r    <= mul_p;
          state_r <= ST_MUL1;
        end
        ST_MUL1: begin
          p1_r    <= mul_p;
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          p2_r    <= mul_p;
          state_r <= ST_FORM;
        end
        ST_FORM: begin
          rn_r    <= rn_form;
          rd_r    <= (cmd_r == CMD_DIV) ? p1_r : p2_r;
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          if (rd_r == '0) begin
            res_num_r <= '0;
            res_den_r <= '0;
            err_r     <= 1'b1;
            valid_r   <= 1'b1;
            state_r   <= ST_IDLE;
          end else if (rn_r == '0) begin
            // zero numerator: hand back the raw denominator unreduced
            res_num_r <= '0;
            res_den_r <= rd_r[30:0];
            err_r     <= 1'b0;
            valid_r   <= 1'b1;
            state_r   <= ST_IDLE;
          end else begin
            state_r <= ST_GCD;
          end
        end
        ST_GCD: begin
          if (gcd_done) begin
            state_r <= ST_DIVN;
          end
        end
        ST_DIVN: begin
          if (div_done) begin
            qn_r    <= div_quot;
            state_r <= ST_DIVD;
          end
        end
        ST_DIVD: begin
          if (div_done) begin
            // restore the signs: division is exact
            res_num_r <= rn_r[32] ? -qn_r : qn_r;
            res_den_r <= rd_r[31] ? quot_neg[30:0] : div_quot[30:0];
            err_r     <= 1'b0;
            valid_r   <= 1'b1;
            state_r   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign out_valid   = valid_r;
  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;
  assign out_err     = err_r;

endmodule

>>> rtl/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd: iterative binary gcd
// One compare/subtract/shift step per cycle over two nonzero magnitudes.
// ----------------------------------------------------------------------------
module rau_gcd
  import rau_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] a_in,
  input  logic [MAG_W-1:0] b_in,
  output logic             done,
  output logic [MAG_W-1:0] gcd
);

  logic [MAG_W-1:0] a_r;
  logic [MAG_W-1:0] b_r;
  logic [MAG_W-1:0] g_r;
  logic [K_W-1:0]   k_r;
  logic             run_r;
  logic             done_r;
  logic             a_gt_b;
  logic [MAG_W-1:0] diff;

  assign a_gt_b = a_r > b_r;
  assign diff   = a_gt_b ? (a_r - b_r) : (b_r - a_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r   <= a_in;
        b_r   <= b_in;
        k_r   <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (b_r == '0) begin
          g_r    <= a_r << k_r;
          done_r <= 1'b1;
          run_r  <= 1'b0;
        end else if (!a_r[0] && !b_r[0]) begin
          // pull out a common factor of two
          a_r <= a_r >> 1;
          b_r <= b_r >> 1;
          k_r <= k_r + K_W'(1);
        end else if (!a_r[0]) begin
          a_r <= a_r >> 1;
        end else if (!b_r[0]) begin
          b_r <= b_r >> 1;
        end else if (a_gt_b) begin
          // both odd: difference is even, halve it right away
          a_r <= diff >> 1;
        end else begin
          b_r <= diff >> 1;
        end
      end
    end
  end

  assign done = done_r;
  assign gcd  = g_r;

endmodule

>>> rtl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div: restoring unsigned divider
// One quotient bit per cycle; shared by the numerator and denominator steps.
// ----------------------------------------------------------------------------
module rau_div
  import rau_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] dividend,
  input  logic [MAG_W-1:0] divisor,
  output logic             done,
  output logic [MAG_W-1:0] quot
);

  logic [MAG_W-1:0] acc_r;
  logic [MAG_W-1:0] q_r;
  logic [MAG_W-1:0] d_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [MAG_W+1:0] trial;
  logic             borrow;

  assign trial  = {1'b0, acc_r, q_r[MAG_W-1]} - {2'b00, d_r};
  assign borrow = trial[MAG_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        acc_r <= '0;
        q_r   <= dividend;
        d_r   <= divisor;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        // keep the partial remainder on borrow, else take the difference
        if (borrow) begin
          acc_r <= {acc_r[MAG_W-2:0], q_r[MAG_W-1]};
        end else begin
          acc_r <= trial[MAG_W-1:0];
        end
        q_r   <= {q_r[MAG_W-2:0], ~borrow};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> tb/sv/rational_arithmetic_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb: self-checking bench for the fraction unit
// Walks a table of directed cases, then about 1350 random ones. Every
// transaction taken by the unit is predicted here in integer arithmetic
// or typed in the table; every strobed result is compared field by field, in order.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb
  import rau_pkg::*;
();

  localparam int RANDOM_ITEMS = 1350;
  localparam int STEADY_ITEMS = 150;
  localparam int CYCLE_LIMIT  = 1_200_000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [31:0] num;
    logic signed [30:0] den;
    logic               err;
  } frac_res_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] num_a;
    logic signed [15:0] den_a;
    logic signed [15:0] num_b;
    logic signed [15:0] den_b;
    logic               known;
    frac_res_t          res;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_cmd;
  logic signed [15:0] in_num_a;
  logic signed [15:0] in_den_a;
  logic signed [15:0] in_num_b;
  logic signed [15:0] in_den_b;
  logic               out_valid;
  logic signed [31:0] out_res_num;
  logic signed [30:0] out_res_den;
  logic               out_err;

  frac_res_t  next_frac;
  frac_res_t  expected_fracs[$];
  int         fail_count;
  int         cycle_count;
  bit         idle_on;
  stim_row_t  directed_rows[0:22];

  rational_arithmetic_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_cmd      (in_cmd),
    .in_num_a    (in_num_a),
    .in_den_a    (in_den_a),
    .in_num_b    (in_num_b),
    .in_den_b    (in_den_b),
    .out_valid   (out_valid),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_err     (out_err)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Cross products over 64 bits, then Euclid on the magnitudes.
  function automatic frac_res_t reduce_fraction_op(logic [1:0] op,
                                                   logic signed [15:0] na,
                                                   logic signed [15:0] da,
                                                   logic signed [15:0] nb,
                                                   logic signed [15:0] db);
    longint          a, b, c, d, rn, rd;
    longint unsigned x, y, t;
    frac_res_t       r;
    a = na;
    b = da;
    c = nb;
    d = db;
    case (op)
      CMD_ADD: begin
        rn = a * d + c * b;
        rd = b * d;
      end
      CMD_SUB: begin
        rn = a * d - c * b;
        rd = b * d;
      end
      CMD_MUL: begin
        rn = a * c;
        rd = b * d;
      end
      default: begin
        rn = a * d;
        rd = c * b;
      end
    endcase
    r = '0;
    if (rd == 0) begin
      r.err = 1'b1;
      return r;
    end
    if (rn != 0) begin
      x = (rn < 0) ? longint'(-rn) : longint'(rn);
      y = (rd < 0) ? longint'(-rd) : longint'(rd);
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      rn = rn / longint'(x);
      rd = rd / longint'(x);
    end
    r.num = rn[31:0];
    r.den = rd[30:0];
    return r;
  endfunction

  function automatic logic signed [15:0] pick_operand();
    logic signed [15:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = 16'($urandom());
      5, 6:          v = 16'($urandom_range(1, 40));
      7:             v = '0;
      8: begin
        case ($urandom_range(0, 4))
          0:       v = 16'sd32767;
          1:       v = -16'sd32767;
          2:       v = 16'sh8000;
          3:       v = 16'sd1;
          default: v = -16'sd1;
        endcase
      end
      default:       v = 16'($urandom_range(1, 7) << $urandom_range(0, 12));
    endcase
    if ($urandom_range(0, 1) && v != 16'sh8000)
      v = -v;
    return v;
  endfunction

  // Leave the transaction on the ports until the unit takes it; return at the
  // following falling edge with start still high.
  task automatic issue_fraction_op(logic [1:0] op, logic signed [15:0] na,
                                   logic signed [15:0] da, logic signed [15:0] nb,
                                   logic signed [15:0] db, logic known,
                                   frac_res_t typed_res);
    int gap;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start = 1'b0;
      // land some gaps after busy has dropped, others during the work
      if ($urandom_range(0, 1))
        while (busy) @(negedge clk);
      gap = $urandom_range(1, 14);
      repeat (gap) @(negedge clk);
    end
    next_frac = known ? typed_res : reduce_fraction_op(op, na, da, nb, db);
    in_cmd    = op;
    in_num_a  = na;
    in_den_a  = da;
    in_num_b  = nb;
    in_den_b  = db;
    start     = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Score results and record each transaction the unit takes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_fracs.size() == 0) begin
          $error("unexpected result: num %0d den %0d err %0d",
                 out_res_num, out_res_den, out_err);
          fail_count++;
        end else begin
          frac_res_t e;
          e = expected_fracs.pop_front();
          if (out_res_num !== e.num) begin
            $error("res_num: expected %0d, actual %0d", e.num, out_res_num);
            fail_count++;
          end
          if (out_res_den !== e.den) begin
            $error("res_den: expected %0d, actual %0d", e.den, out_res_den);
            fail_count++;
          end
          if (out_err !== e.err) begin
            $error("err: expected %0d, actual %0d", e.err, out_err);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        expected_fracs.push_back(next_frac);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    fail_count  = 0;
    cycle_count = 0;
    idle_on     = 1'b1;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_cmd      = CMD_ADD;
    in_num_a    = '0;
    in_den_a    = '0;
    in_num_b    = '0;
    in_den_b    = '0;
    next_frac   = '0;

    directed_rows = '{
      '{CMD_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b0, '0},
      '{CMD_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2, 1'b1, '{32'sd0, 31'sd4, 1'b0}},
      '{CMD_MUL, 16'sd0, 16'sd6, 16'sd5, 16'sd4, 1'b1, '{32'sd0, 31'sd24, 1'b0}},
      '{CMD_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5, 1'b1, '{32'sd0, 31'sd0, 1'b1}},
      '{CMD_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd2, 1'b1, '{32'sd0, 31'sd0, 1'b1}},
      '{CMD_SUB, 16'sd7, 16'sd3, 16'sd2, 16'sd0, 1'b1, '{32'sd0, 31'sd0, 1'b1}},
      '{CMD_MUL, 16'sd5, 16'sd0, 16'sd3, 16'sd0, 1'b1, '{32'sd0, 31'sd0, 1'b1}},
      '{CMD_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{32'sd0, 31'sd0, 1'b1}},
      '{CMD_MUL, 16'sd32767, 16'sd1, 16'sd32767, 16'sd1, 1'b1,
        '{32'sd1073676289, 31'sd1, 1'b0}},
      '{CMD_MUL, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1, 1'b1,
        '{32'sd1073741824, 31'sd1, 1'b0}},
      '{CMD_MUL, 16'sd1, 16'sh8000, 16'sd1, 16'sh8000, 1'b0, '0},
      '{CMD_ADD, 16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000, 1'b0, '0},
      '{CMD_SUB, 16'sh8000, 16'sd32767, 16'sd32767, 16'sh8000, 1'b0, '0},
      '{CMD_DIV, 16'sh8000, 16'sd32767, 16'sd32767, 16'sh8000, 1'b0, '0},
      '{CMD_DIV, 16'sd6, 16'sd4, 16'sd3, 16'sd2, 1'b1, '{32'sd1, 31'sd1, 1'b0}},
      '{CMD_ADD, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1, '{32'sd2, 31'sd1, 1'b0}},
      '{CMD_MUL, 16'sd1, -16'sd2, 16'sd1, 16'sd3, 1'b1, '{32'sd1, -31'sd6, 1'b0}},
      '{CMD_ADD, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
      '{CMD_DIV, 16'sd32767, 16'sd1, 16'sd1, 16'sd32767, 1'b1,
        '{32'sd1073676289, 31'sd1, 1'b0}},
      '{CMD_MUL, -16'sd32767, 16'sd1, 16'sd32767, 16'sd1, 1'b1,
        '{-32'sd1073676289, 31'sd1, 1'b0}},
      '{CMD_SUB, 16'sd5, 16'sd7, -16'sd3, -16'sd11, 1'b0, '0},
      '{CMD_ADD, 16'sd0, 16'sd5, 16'sd0, -16'sd3, 1'b1, '{32'sd0, -31'sd15, 1'b0}},
      '{CMD_DIV, 16'sd12345, 16'sh8000, 16'sh8000, 16'sd4321, 1'b0, '0}
    };

    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      issue_fraction_op(directed_rows[i].cmd, directed_rows[i].num_a,
                        directed_rows[i].den_a, directed_rows[i].num_b,
                        directed_rows[i].den_b, directed_rows[i].known,
                        directed_rows[i].res);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      logic signed [15:0] na, da, nb, db;
      // run back to back toward the end
      idle_on = (n < RANDOM_ITEMS - STEADY_ITEMS);
      na = pick_operand();
      da = pick_operand();
      nb = pick_operand();
      db = pick_operand();
      issue_fraction_op(2'($urandom_range(0, 3)), na, da, nb, db, 1'b0, '0);
    end
    start = 1'b0;

    while (expected_fracs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/rau_pkg.sv
rtl/rau_gcd.sv
rtl/rau_div.sv
rtl/rational_arithmetic_unit.sv
tb/sv/rational_arithmetic_unit_tb.sv
